// ===== rtl/tlbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared types, constants and helpers of the two-level branch predictor.
// ----------------------------------------------------------------------------
package tlbp_pkg;

    localparam int BtbEntries  = 32;
    localparam int HistoryMax  = 8;
    localparam int TableMax    = 1 << HistoryMax;
    localparam int EntryW      = $clog2(BtbEntries);
    localparam int LocalDepth  = BtbEntries * TableMax;
    localparam int LocalAw     = $clog2(LocalDepth);
    localparam int TagW        = 30;
    localparam int CfgAw       = 5;

    localparam logic [2:0] IndexBitsReset   = 3'd5;
    localparam logic [3:0] HistoryLenReset  = 4'd8;
    localparam logic [4:0] TagLenReset      = 5'd16;
    localparam logic [1:0] CounterInitReset = 2'd1;

    typedef enum logic [2:0] {
        REG_INDEX_BITS  = 3'd0,
        REG_HISTORY_LEN = 3'd1,
        REG_TAG_LEN     = 3'd2,
        REG_COUNTER_INIT = 3'd3,
        REG_GLOBAL_HIST = 3'd4,
        REG_GLOBAL_TABLE = 3'd5,
        REG_SHARE_MODE  = 3'd6,
        REG_NONE        = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_PREDICT = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SHARE_HIST   = 2'd0,
        SHARE_PC_LO  = 2'd1,
        SHARE_PC_HI  = 2'd2,
        SHARE_RSVD   = 2'd3
    } share_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_ROW_FILL,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_PRED_RD
    } bstate_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] pc;
        logic [31:0] actual_target;
        logic        actual_taken;
        logic [31:0] predicted_dest;
    } in_item_t;

    typedef struct packed {
        logic        pred_taken;
        logic [31:0] pred_next_pc;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } out_item_t;

    typedef struct packed {
        cmd_t        kind;
        logic [31:0] pc;
        logic [31:0] actual_target;
        logic        actual_taken;
        logic [31:0] predicted_dest;
    } q_item_t;

    typedef struct packed {
        logic [2:0] index_bits;
        logic [3:0] history_len;
        logic [4:0] tag_len;
        logic [1:0] counter_init;
        logic       use_global_history;
        logic       use_global_table;
        logic [1:0] share_mode;
    } cfg_t;

    // saturating 2-bit counter step
    function automatic logic [1:0] train_ctr(input logic [1:0] c, input logic taken);
        logic [1:0] r;
        r = c;
        if (taken && c != 2'd3) r = c + 2'd1;
        else if (!taken && c != 2'd0) r = c - 2'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tlbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbp_ram #(
    parameter int Width = 2,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tlbp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_cfg
// APB register file holding the predictor configuration.
// ----------------------------------------------------------------------------
module tlbp_cfg
    import tlbp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [CfgAw-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output cfg_t                  cfg
);
    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[CfgAw-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.index_bits         <= IndexBitsReset;
            cfg_reg.history_len        <= HistoryLenReset;
            cfg_reg.tag_len            <= TagLenReset;
            cfg_reg.counter_init       <= CounterInitReset;
            cfg_reg.use_global_history <= 1'b0;
            cfg_reg.use_global_table   <= 1'b0;
            cfg_reg.share_mode         <= 2'd0;
        end else if (wr_en) begin
            unique case (widx)
                REG_INDEX_BITS:   cfg_reg.index_bits         <= pwdata[2:0];
                REG_HISTORY_LEN:  cfg_reg.history_len        <= pwdata[3:0];
                REG_TAG_LEN:      cfg_reg.tag_len            <= pwdata[4:0];
                REG_COUNTER_INIT: cfg_reg.counter_init       <= pwdata[1:0];
                REG_GLOBAL_HIST:  cfg_reg.use_global_history <= pwdata[0];
                REG_GLOBAL_TABLE: cfg_reg.use_global_table   <= pwdata[0];
                REG_SHARE_MODE:   cfg_reg.share_mode         <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_INDEX_BITS:   prdata = {29'd0, cfg_reg.index_bits};
            REG_HISTORY_LEN:  prdata = {28'd0, cfg_reg.history_len};
            REG_TAG_LEN:      prdata = {27'd0, cfg_reg.tag_len};
            REG_COUNTER_INIT: prdata = {30'd0, cfg_reg.counter_init};
            REG_GLOBAL_HIST:  prdata = {31'd0, cfg_reg.use_global_history};
            REG_GLOBAL_TABLE: prdata = {31'd0, cfg_reg.use_global_table};
            REG_SHARE_MODE:   prdata = {30'd0, cfg_reg.share_mode};
            default:          prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/tlbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_front
// Accepts transactions, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
module tlbp_front
    import tlbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     hold,
    output logic          q_valid,
    output q_item_t       q_item,
    input  wire logic     q_pop
);
    q_item_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    q_item_t    item;

    assign s_ready = (count_reg != 2'd2) && !hold;
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != 2'd0;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        item.kind           = cmd_t'(s_data.command);
        item.pc             = s_data.pc;
        item.actual_target  = s_data.actual_target;
        item.actual_taken   = s_data.actual_taken;
        item.predicted_dest = s_data.predicted_dest;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != 2'd0) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count slip");
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        hold |-> !push) else $error("push during clearing pass");
`endif
endmodule
`default_nettype wire

// ===== rtl/tlbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_back
// Executes queued transactions: BTB lookup, counter tables, training,
// table fills and statistics.
// ----------------------------------------------------------------------------
module tlbp_back
    import tlbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     q_valid,
    input  wire q_item_t  q_item,
    output logic          q_pop,
    output logic          hold,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);
    bstate_t             state_reg, state_next;
    q_item_t             cur_reg;
    logic [LocalAw-1:0]  cnt_reg, cnt_next;
    logic [1:0]          fill_val_reg, fill_val_next;
    logic                emit_done_reg, emit_done_next;
    logic [EntryW-1:0]   e_reg, e_next;
    logic                hit_reg, hit_next;
    logic [HistoryMax-1:0] idx_reg, idx_next;

    logic [BtbEntries-1:0] valid_reg, valid_next;
    logic [TagW-1:0]       tag_reg  [BtbEntries];
    logic [31:0]           tgt_reg  [BtbEntries];
    logic [HistoryMax-1:0] hist_reg [BtbEntries];
    logic [HistoryMax-1:0] shist_reg, shist_next;
    logic                  last_pt_reg, last_pt_next;
    logic [31:0]           branches_reg, branches_next;
    logic [31:0]           flushes_reg, flushes_next;

    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;

    // entry write controls
    logic                  ent_alloc, ent_tgt_we, hist_we, hist_clr;
    logic [HistoryMax-1:0] hist_wval;

    // derived lookup values
    logic [2:0]            ib_eff;
    logic [3:0]            hl_eff;
    logic [4:0]            tl_eff;
    logic [HistoryMax-1:0] hmask;
    logic [EntryW-1:0]     e_cur;
    logic [TagW-1:0]       tag_cur;
    logic [HistoryMax-1:0] hsel, tidx;
    logic                  tag_hit;

    // ram ports
    logic                  l_we, g_we;
    logic [LocalAw-1:0]    l_waddr, l_raddr;
    logic [HistoryMax-1:0] g_waddr, g_raddr;
    logic [1:0]            l_wdata, g_wdata, l_rdata, g_rdata, ctr;

    tlbp_ram #(.Width(2), .Depth(LocalDepth)) u_local (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );
    tlbp_ram #(.Width(2), .Depth(TableMax)) u_global (
        .aclk(aclk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign hold    = (state_reg == ST_SWEEP) && !emit_done_reg;
    assign ctr     = cfg.use_global_table ? g_rdata : l_rdata;

    always_comb begin
        logic [31:0] emask, tmask, tshift;
        ib_eff = (cfg.index_bits > 3'd5) ? 3'd5 : cfg.index_bits;
        hl_eff = (cfg.history_len == 4'd0) ? 4'd1 :
                 (cfg.history_len > 4'(HistoryMax)) ? 4'(HistoryMax) : cfg.history_len;
        tl_eff = (cfg.tag_len > 5'd30) ? 5'd30 : cfg.tag_len;
        hmask  = HistoryMax'((9'd1 << hl_eff) - 9'd1);
        emask  = (32'd1 << ib_eff) - 32'd1;
        e_cur  = EntryW'((cur_reg.pc >> 2) & emask);
        tmask  = (32'd1 << tl_eff) - 32'd1;
        tshift = cur_reg.pc >> (6'd2 + 6'(ib_eff));
        tag_cur = TagW'(tshift & tmask);
        tag_hit = valid_reg[e_cur] && (tag_reg[e_cur] == tag_cur);
        hsel = (cfg.use_global_history ? shist_reg : hist_reg[e_cur]) & hmask;
        tidx = hsel;
        if (cfg.use_global_table) begin
            if (share_t'(cfg.share_mode) == SHARE_PC_LO) begin
                tidx = hsel ^ (cur_reg.pc[2 +: HistoryMax] & hmask);
            end else if (share_t'(cfg.share_mode) == SHARE_PC_HI) begin
                tidx = hsel ^ (cur_reg.pc[16 +: HistoryMax] & hmask);
            end
        end
    end

    always_comb begin
        logic flush;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_val_next  = fill_val_reg;
        emit_done_next = emit_done_reg;
        e_next         = e_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        shist_next     = shist_reg;
        last_pt_next   = last_pt_reg;
        branches_next  = branches_reg;
        flushes_next   = flushes_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        ent_alloc      = 1'b0;
        ent_tgt_we     = 1'b0;
        hist_we        = 1'b0;
        hist_clr       = 1'b0;
        hist_wval      = '0;
        l_we           = 1'b0;
        g_we           = 1'b0;
        l_waddr        = cnt_reg;
        g_waddr        = cnt_reg[HistoryMax-1:0];
        l_wdata        = fill_val_reg;
        g_wdata        = fill_val_reg;
        l_raddr        = {e_cur, tidx};
        g_raddr        = tidx;
        flush          = (cur_reg.actual_taken != last_pt_reg) ||
                         (last_pt_reg && cur_reg.predicted_dest != cur_reg.actual_target);

        unique case (state_reg)
            ST_IDLE: begin
                // the result slot only drains, so it is still free at emit time
                if (q_valid && (!out_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                e_next = e_cur;
                unique case (cur_reg.kind)
                    CMD_INIT: begin
                        valid_next     = '0;
                        hist_clr       = 1'b1;
                        shist_next     = '0;
                        last_pt_next   = 1'b0;
                        branches_next  = '0;
                        flushes_next   = '0;
                        fill_val_next  = cfg.counter_init;
                        emit_done_next = 1'b1;
                        cnt_next       = '0;
                        state_next     = ST_SWEEP;
                    end
                    CMD_PREDICT: begin
                        hit_next   = tag_hit;
                        state_next = ST_PRED_RD;
                    end
                    CMD_UPDATE: begin
                        if (flush) flushes_next = flushes_reg + 32'd1;
                        branches_next = branches_reg + 32'd1;
                        if (!tag_hit) begin
                            valid_next[e_cur] = 1'b1;
                            ent_alloc = 1'b1;
                            if (!cfg.use_global_history) begin
                                hist_we   = 1'b1;
                                hist_wval = '0;
                            end
                        end else if (cur_reg.actual_target != cur_reg.predicted_dest) begin
                            ent_tgt_we = 1'b1;
                        end
                        if (!tag_hit && !cfg.use_global_table) begin
                            fill_val_next = cfg.counter_init;
                            cnt_next      = '0;
                            state_next    = ST_ROW_FILL;
                        end else begin
                            state_next = ST_UPD_RD;
                        end
                    end
                    default: begin
                        out_valid_next = 1'b1;
                        out_next = '{pred_taken: 1'b0, pred_next_pc: 32'd0,
                                     branch_count: branches_reg, flush_count: flushes_reg};
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SWEEP: begin
                l_we = 1'b1;
                g_we = cnt_reg[LocalAw-1:HistoryMax] == '0;
                cnt_next = cnt_reg + LocalAw'(1);
                if (cnt_reg == LocalAw'(LocalDepth - 1)) begin
                    state_next = ST_IDLE;
                    if (emit_done_reg) begin
                        out_valid_next = 1'b1;
                        out_next = '{pred_taken: 1'b0, pred_next_pc: 32'd0,
                                     branch_count: branches_reg, flush_count: flushes_reg};
                    end
                end
            end
            ST_ROW_FILL: begin
                l_we     = 1'b1;
                l_waddr  = {e_reg, cnt_reg[HistoryMax-1:0]};
                cnt_next = cnt_reg + LocalAw'(1);
                if (cnt_reg[HistoryMax-1:0] == HistoryMax'(TableMax - 1)) begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD: begin
                idx_next   = tidx;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                l_waddr = {e_reg, idx_reg};
                g_waddr = idx_reg;
                l_wdata = train_ctr(ctr, cur_reg.actual_taken);
                g_wdata = l_wdata;
                l_we    = !cfg.use_global_table;
                g_we    = cfg.use_global_table;
                if (cfg.use_global_history) begin
                    shist_next = {shist_reg[HistoryMax-2:0], cur_reg.actual_taken} & hmask;
                end else begin
                    hist_we   = 1'b1;
                    hist_wval = {hist_reg[e_reg][HistoryMax-2:0], cur_reg.actual_taken} & hmask;
                end
                out_valid_next = 1'b1;
                out_next = '{pred_taken: 1'b0, pred_next_pc: 32'd0,
                             branch_count: branches_reg, flush_count: flushes_reg};
                state_next = ST_IDLE;
            end
            ST_PRED_RD: begin
                out_valid_next = 1'b1;
                out_next.branch_count = branches_reg;
                out_next.flush_count  = flushes_reg;
                if (hit_reg && ctr >= 2'd2) begin
                    out_next.pred_taken   = 1'b1;
                    out_next.pred_next_pc = tgt_reg[e_reg];
                    last_pt_next = 1'b1;
                end else begin
                    out_next.pred_taken   = 1'b0;
                    out_next.pred_next_pc = cur_reg.pc + 32'd4;
                    last_pt_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            cnt_reg       <= '0;
            fill_val_reg  <= CounterInitReset;
            emit_done_reg <= 1'b0;
            valid_reg     <= '0;
            shist_reg     <= '0;
            last_pt_reg   <= 1'b0;
            branches_reg  <= '0;
            flushes_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_val_reg  <= fill_val_next;
            emit_done_reg <= emit_done_next;
            valid_reg     <= valid_next;
            shist_reg     <= shist_next;
            last_pt_reg   <= last_pt_next;
            branches_reg  <= branches_next;
            flushes_reg   <= flushes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BtbEntries; i++) hist_reg[i] <= '0;
        end else if (hist_clr) begin
            for (int i = 0; i < BtbEntries; i++) hist_reg[i] <= '0;
        end else if (hist_we) begin
            hist_reg[(state_reg == ST_EXEC) ? e_cur : e_reg] <= hist_wval;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_item;
        e_reg   <= e_next;
        hit_reg <= hit_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
        if (ent_alloc) tag_reg[e_cur] <= tag_cur;
        if (ent_alloc || ent_tgt_we) tgt_reg[e_cur] <= cur_reg.actual_target;
    end

`ifndef SYNTHESIS
    a_pop_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!out_valid_reg || m_ready)) else $error("pop with result slot busy");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE) else $error("pop while busy");
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && out_valid_next) |=> state_reg == ST_IDLE)
        else $error("result emitted outside completion");
    a_write_one_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD_WR) |-> (l_we != g_we)) else $error("trained both tables");
`endif
endmodule
`default_nettype wire

// ===== rtl/two_level_branch_predictor_btb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_branch_predictor_btb_top
// Two-level branch predictor with a direct-mapped branch target buffer.
// ----------------------------------------------------------------------------
// Input channel s_*: one command per transaction (initialize, predict, update).
// Output channel m_*: exactly one result per command: predicted direction and
// next pc on predict, plus branch and flush counts after the command.
// Configuration: APB registers at byte offsets 4*i, to be written only while
// idle; the user is bound by this, the block itself does not enforce it.
// A two-entry queue sits between the decoding front end and the execution
// back end, so new transactions are taken while a result waits on m_ready.
// One command at a time is executed: a predict passes EXEC and PRED_RD, an
// update that hits EXEC, UPD_RD and UPD_WR, an unknown command EXEC only,
// before m_valid rises; the next command leaves the queue only after that.
// An update that allocates an entry with per-entry tables refills that
// entry's 256-counter row first. Initialize rewrites all 8192 local counters
// (and the 256 global ones) at one per cycle. After reset the same clearing
// pass runs with s_ready low. A stalled receiver holds the result register;
// the queue then fills and s_ready drops.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_btb_top
    import tlbp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [CfgAw-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);
    cfg_t    cfg;
    logic    q_valid, q_pop, hold;
    q_item_t q_item;

    tlbp_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    tlbp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .hold(hold), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop)
    );

    tlbp_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .q_valid(q_valid),
        .q_item(q_item), .q_pop(q_pop), .hold(hold), .m_valid(m_valid),
        .m_ready(m_ready), .m_data(m_data)
    );
endmodule
`default_nettype wire
